/* src/one_wire_bus_master_assert.svh */
// Assertion macros for the one-wire bus master.
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define OWBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("owbm: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define OWBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("owbm: next-cycle check failed");

`endif

/* src/owbm_pkg.sv */
// Shared types and constants of the one-wire bus master.
`timescale 1ns / 1ps
`default_nettype none
package owbm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BYTE_W        = 8;
  localparam int BIT_CNT_W     = 4;
  localparam int TIME_W        = 10;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 10;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL     = 3'd6;

  // Register reset values.
  localparam logic [TIME_W-1:0] RST_RESET_LOW     = 10'd480;
  localparam logic [TIME_W-1:0] RST_PRESENCE_WAIT = 10'd80;
  localparam logic [TIME_W-1:0] RST_RESET_TAIL    = 10'd400;
  localparam logic [BYTE_W-1:0] RST_SHORT_LOW     = 8'd1;
  localparam logic [BYTE_W-1:0] RST_SLOT          = 8'd60;
  localparam logic [BYTE_W-1:0] RST_READ_LOW      = 8'd2;
  localparam logic [BYTE_W-1:0] RST_READ_TAIL     = 8'd60;

  // Operation codes.
  localparam logic [1:0] OP_RESET = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic              command_valid;
    logic [1:0]        operation;
    logic [BYTE_W-1:0] write_value;
    logic              line_level;
  } cmd_word_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              presence_found;
    logic [BYTE_W-1:0] read_value;
    logic              command_rejected;
  } res_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] reset_low_time;
    logic [TIME_W-1:0] presence_wait_time;
    logic [TIME_W-1:0] reset_tail_time;
    logic [BYTE_W-1:0] short_low_time;
    logic [BYTE_W-1:0] slot_time;
    logic [BYTE_W-1:0] read_low_time;
    logic [BYTE_W-1:0] read_tail_time;
  } cfg_t;

endpackage
`default_nettype wire

/* src/one_wire_bus_master.sv */
// Top level of the one-wire bus master: tick input register, sequencer, result register.
// Path: a word is held in the input register until the sequencer moves it into a free
//   result register.
// Throughput: one tick word per cycle while results are taken; one sequencer step per word.
// Reset: synchronous, active high; clears the sequencer to idle, presence and read byte to
//   zero, and loads the timing registers with their defaults. No memories, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "one_wire_bus_master_assert.svh"
module one_wire_bus_master
  import owbm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Tick words in.
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire cmd_word_t             cmd_word,
  // Result words out.
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output res_word_t                  res_word,
  // Timing register writes.
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Input register: holds one tick word until the sequencer takes it.
  logic      in_valid;
  cmd_word_t in_word;
  // Advance one word from the input register through the sequencer into the result register.
  logic      step;
  res_word_t step_res;

  // Advance when a word is held and the result register is empty or being drained this cycle.
  assign step      = in_valid && (!res_valid || res_ready);
  // Take a new word when the input register is empty or moves on in this cycle.
  assign cmd_ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd_ready) begin
      in_valid <= cmd_valid;
    end
  end

  // Payload needs no reset; load it only on acceptance.
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      in_word <= cmd_word;
    end
  end

  // Sequencer: the state update for one tick happens in the cycle the word steps.
  owbm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .step         (step),
    .word         (in_word),
    .res          (step_res)
  );

  // Result register: hold the word until the far side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_word <= step_res;
    end
  end

  // A finished command always belongs to a busy tick.
  `OWBM_ASSERT_NOW(a_done_busy, res_valid && res_word.done_res, res_word.busy_res)
  // The line is only pulled low during a command.
  `OWBM_ASSERT_NOW(a_drive_busy, res_valid && res_word.drive_low, res_word.busy_res)
  // An empty result register never blocks the input side.
  `OWBM_ASSERT_NOW(a_ready_empty, !res_valid, cmd_ready)
  // A stalled result is not dropped.
  `OWBM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)

endmodule
`default_nettype wire

/* src/owbm_core.sv */
// Slot sequencer and timing registers of the one-wire bus master.
`timescale 1ns / 1ps
`default_nettype none
module owbm_core
  import owbm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  step,
  input  wire cmd_word_t             word,
  output res_word_t                  res
);

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_RST_LOW    = 4'd1;
  localparam logic [3:0] PH_RST_WAIT   = 4'd2;
  localparam logic [3:0] PH_RST_SAMPLE = 4'd3;
  localparam logic [3:0] PH_RST_TAIL   = 4'd4;
  localparam logic [3:0] PH_WR_LOW     = 4'd5;
  localparam logic [3:0] PH_WR_REL     = 4'd6;
  localparam logic [3:0] PH_RD_LOW     = 4'd7;
  localparam logic [3:0] PH_RD_SAMPLE  = 4'd8;
  localparam logic [3:0] PH_RD_TAIL    = 4'd9;

  localparam logic [TIME_W-1:0] ONE_TICK = TIME_W'(1);

  typedef struct packed {
    logic [3:0]           phase;
    logic [TIME_W-1:0]    time_left;
    logic [BIT_CNT_W-1:0] bits_left;
    logic [BYTE_W-1:0]    shift_byte;
    logic [BYTE_W-1:0]    read_result;
  } seq_t;

  cfg_t  cfg;
  seq_t  seq;
  seq_t  seq_next;
  logic  presence;
  logic  presence_next;
  logic  run;

  function automatic logic [TIME_W-1:0] widen(input logic [BYTE_W-1:0] v);
    return {{(TIME_W-BYTE_W){1'b0}}, v};
  endfunction

  function automatic seq_t set_phase(input seq_t s, input logic [3:0] p,
                                     input logic [TIME_W-1:0] t);
    seq_t r;
    r = s;
    r.phase = p;
    r.time_left = t;
    return r;
  endfunction

  // Enter a write slot; skip whole one-bits whose low and release times are zero.
  function automatic seq_t wr_enter(input seq_t s, input cfg_t c);
    seq_t r;
    logic stop;
    r = s;
    stop = 1'b0;
    for (int i = 0; i < BITS_PER_BYTE; i++) begin
      if (!stop) begin
        if (r.shift_byte[0] && c.short_low_time == '0 && c.slot_time == '0) begin
          r.shift_byte = r.shift_byte >> 1;
          if (r.bits_left != '0) r.bits_left = r.bits_left - 1'b1;
          if (r.bits_left == '0) begin
            r = set_phase(r, PH_IDLE, '0);
            stop = 1'b1;
          end
        end else begin
          stop = 1'b1;
          if (r.shift_byte[0]) begin
            if (c.short_low_time != '0) r = set_phase(r, PH_WR_LOW, widen(c.short_low_time));
            else r = set_phase(r, PH_WR_REL, widen(c.slot_time));
          end else begin
            if (c.slot_time != '0) r = set_phase(r, PH_WR_LOW, widen(c.slot_time));
            else r = set_phase(r, PH_WR_REL, ONE_TICK);
          end
        end
      end
    end
    return r;
  endfunction

  function automatic seq_t wr_rel_end(input seq_t s, input cfg_t c);
    seq_t r;
    r = s;
    r.shift_byte = r.shift_byte >> 1;
    if (r.bits_left != '0) r.bits_left = r.bits_left - 1'b1;
    if (r.bits_left == '0) r = set_phase(r, PH_IDLE, '0);
    else r = wr_enter(r, c);
    return r;
  endfunction

  function automatic seq_t rd_low_enter(input seq_t s, input cfg_t c);
    if (c.read_low_time != '0) return set_phase(s, PH_RD_LOW, widen(c.read_low_time));
    return set_phase(s, PH_RD_SAMPLE, ONE_TICK);
  endfunction

  function automatic seq_t rd_tail_end(input seq_t s, input cfg_t c);
    seq_t r;
    r = s;
    if (r.bits_left != '0) r.bits_left = r.bits_left - 1'b1;
    if (r.bits_left != '0) begin
      r = rd_low_enter(r, c);
    end else begin
      r.read_result = r.shift_byte;
      r = set_phase(r, PH_IDLE, '0);
    end
    return r;
  endfunction

  function automatic seq_t rst_wait_enter(input seq_t s, input cfg_t c);
    if (c.presence_wait_time != '0)
      return set_phase(s, PH_RST_WAIT, c.presence_wait_time);
    return set_phase(s, PH_RST_SAMPLE, ONE_TICK);
  endfunction

  function automatic seq_t rst_low_enter(input seq_t s, input cfg_t c);
    if (c.reset_low_time != '0) return set_phase(s, PH_RST_LOW, c.reset_low_time);
    return rst_wait_enter(s, c);
  endfunction

  // Leave the current period when its count runs out.
  function automatic seq_t advance(input seq_t s, input cfg_t c);
    seq_t r;
    r = s;
    case (s.phase)
      PH_RST_LOW:    r = rst_wait_enter(s, c);
      PH_RST_WAIT:   r = set_phase(s, PH_RST_SAMPLE, ONE_TICK);
      PH_RST_SAMPLE: begin
        if (c.reset_tail_time != '0) r = set_phase(s, PH_RST_TAIL, c.reset_tail_time);
        else r = set_phase(s, PH_IDLE, '0);
      end
      PH_WR_LOW: begin
        if (!s.shift_byte[0]) r = set_phase(s, PH_WR_REL, ONE_TICK);
        else if (c.slot_time != '0) r = set_phase(s, PH_WR_REL, widen(c.slot_time));
        else r = wr_rel_end(s, c);
      end
      PH_WR_REL:     r = wr_rel_end(s, c);
      PH_RD_LOW:     r = set_phase(s, PH_RD_SAMPLE, ONE_TICK);
      PH_RD_SAMPLE: begin
        if (c.read_tail_time != '0) r = set_phase(s, PH_RD_TAIL, widen(c.read_tail_time));
        else r = rd_tail_end(s, c);
      end
      PH_RD_TAIL:    r = rd_tail_end(s, c);
      default:       r = set_phase(s, PH_IDLE, '0);
    endcase
    return r;
  endfunction

  always_comb begin
    seq_next = seq;
    presence_next = presence;
    res = '0;
    run = 1'b0;
    if (seq.phase == PH_IDLE) begin
      if (word.command_valid) begin
        seq_next.bits_left = BIT_CNT_W'(BITS_PER_BYTE);
        res.busy_res = 1'b1;
        case (word.operation)
          OP_RESET: seq_next = rst_low_enter(seq_next, cfg);
          OP_WRITE: begin
            seq_next.shift_byte = word.write_value;
            seq_next = wr_enter(seq_next, cfg);
          end
          OP_READ: begin
            seq_next.shift_byte = '0;
            seq_next = rd_low_enter(seq_next, cfg);
          end
          default: begin
            seq_next = seq;
            res.busy_res = 1'b0;
            res.command_rejected = 1'b1;
          end
        endcase
        run = res.busy_res && seq_next.phase != PH_IDLE;
      end
    end else begin
      res.busy_res = 1'b1;
      res.command_rejected = word.command_valid;
      run = 1'b1;
    end

    if (run) begin
      res.drive_low = seq_next.phase == PH_RST_LOW || seq_next.phase == PH_WR_LOW ||
                      seq_next.phase == PH_RD_LOW;
      if (seq_next.phase == PH_RST_SAMPLE) presence_next = !word.line_level;
      if (seq_next.phase == PH_RD_SAMPLE)
        seq_next.shift_byte = {word.line_level, seq_next.shift_byte[BYTE_W-1:1]};
      if (seq_next.time_left != '0) seq_next.time_left = seq_next.time_left - 1'b1;
      if (seq_next.time_left == '0) seq_next = advance(seq_next, cfg);
    end

    res.done_res = res.busy_res && seq_next.phase == PH_IDLE;
    res.presence_found = presence_next;
    res.read_value = seq_next.read_result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq.phase       <= PH_IDLE;
      seq.time_left   <= '0;
      seq.bits_left   <= '0;
      seq.shift_byte  <= '0;
      seq.read_result <= '0;
      presence        <= 1'b0;
    end else if (step) begin
      seq      <= seq_next;
      presence <= presence_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_time     <= RST_RESET_LOW;
      cfg.presence_wait_time <= RST_PRESENCE_WAIT;
      cfg.reset_tail_time    <= RST_RESET_TAIL;
      cfg.short_low_time     <= RST_SHORT_LOW;
      cfg.slot_time          <= RST_SLOT;
      cfg.read_low_time      <= RST_READ_LOW;
      cfg.read_tail_time     <= RST_READ_TAIL;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_RESET_LOW:     cfg.reset_low_time     <= cfg_data;
        REG_PRESENCE_WAIT: cfg.presence_wait_time <= cfg_data;
        REG_RESET_TAIL:    cfg.reset_tail_time    <= cfg_data;
        REG_SHORT_LOW:     cfg.short_low_time     <= cfg_data[BYTE_W-1:0];
        REG_SLOT:          cfg.slot_time          <= cfg_data[BYTE_W-1:0];
        REG_READ_LOW:      cfg.read_low_time      <= cfg_data[BYTE_W-1:0];
        REG_READ_TAIL:     cfg.read_tail_time     <= cfg_data[BYTE_W-1:0];
        default:           cfg <= cfg;
      endcase
    end
  end

endmodule
`default_nettype wire
